// ===== hw/rtl/dtmh_pkg.sv =====
package dtmh_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH  = 3'd0,
		MODE_PEEK  = 3'd1,
		MODE_REM   = 3'd2,
		MODE_MARK  = 3'd3,
		MODE_RESCH = 3'd4
	} mode_e;

	localparam logic [31:0] CAP_RESET  = 32'd3600;
	localparam logic [2:0]  COND_RESET = 3'd1;
	localparam logic        REG_CAP    = 1'b0;
	localparam logic        REG_COND   = 1'b1;

	// One heap entry as stored.
	typedef struct packed {
		logic [31:0] dev;
		logic [31:0] next_time;
		logic [31:0] interval;
		logic [7:0]  retries;
		logic [2:0]  status;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] now_time;
		logic [31:0] task_dev;
		logic [31:0] task_next_time;
		logic [31:0] task_interval;
		logic [7:0]  task_retries;
		logic [2:0]  task_status;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] out_dev;
		logic [31:0] out_next_time;
		logic [31:0] out_interval;
		logic [7:0]  out_retries;
		logic [2:0]  out_status;
		logic [6:0]  out_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOP_RD,
		ST_TOP_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_LAST_RD,
		ST_UP_RD,
		ST_UP_CHK,
		ST_DN_RD,
		ST_DN_RD2,
		ST_DN_CHK,
		ST_DONE
	} state_e;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_req;
		logic rd_top;
		logic rd_scan;
		logic rd_last;
		logic rd_parent;
		logic rd_left;
		logic rd_right;
		logic cap_a;
		logic cap_l;
		logic set_hole_scan;
		logic set_hole_top;
		logic init_push;
		logic init_resch;
		logic scan_next;
		logic write_mark;
		logic up_step;
		logic dn_step;
		logic put_hole;
		logic cnt_dec;
		logic cnt_inc;
		logic set_ok;
		logic set_peek;
		logic emit;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [2:0] mode;
		logic full;
		logic empty;
		logic due;
		logic scan_hit;
		logic scan_end;
		logic hole_is_last;
		logic hole_root;
		logic up_swap;
		logic has_left;
		logic has_right;
		logic dn_swap;
		logic after_rem;
	} sts_t;

endpackage

// ===== hw/rtl/dtmh_ram.sv =====
module dtmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/dtmh_ctrl.sv =====
module dtmh_ctrl import dtmh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d = ST_TOP_RD;
				end
			end
			ST_TOP_RD: begin
				// Dispatch on mode; the top read serves peek and reschedule.
				cmd.rd_top = 1'b1;
				unique case (sts.mode)
					MODE_PUSH: begin
						if (sts.full) begin
							state_d = ST_DONE;
						end else begin
							cmd.init_push = 1'b1;
							cmd.set_ok = 1'b1;
							state_d = ST_UP_RD;
						end
					end
					MODE_PEEK, MODE_RESCH: state_d = sts.empty ? ST_DONE : ST_TOP_CHK;
					MODE_REM, MODE_MARK: begin
						cmd.rd_top = 1'b0;
						cmd.rd_scan = 1'b1;
						state_d = sts.empty ? ST_DONE : ST_SCAN_CHK;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_TOP_CHK: begin
				cmd.cap_a = 1'b1;
				if (!sts.due) begin
					state_d = ST_DONE;
				end else if (sts.mode == MODE_PEEK) begin
					cmd.set_ok = 1'b1;
					cmd.set_peek = 1'b1;
					state_d = ST_DONE;
				end else begin
					// Pop the top; the updated task is pushed after the sift.
					cmd.set_ok = 1'b1;
					cmd.set_hole_top = 1'b1;
					cmd.cnt_dec = 1'b1;
					state_d = ST_LAST_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd_scan = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.scan_hit) begin
					cmd.set_ok = 1'b1;
					cmd.set_hole_scan = 1'b1;
					if (sts.mode == MODE_MARK) begin
						cmd.write_mark = 1'b1;
						state_d = ST_DONE;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d = ST_LAST_RD;
					end
				end else if (sts.scan_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_LAST_RD: begin
				// Count is already decremented; read the old last entry.
				cmd.rd_last = 1'b1;
				if (sts.hole_is_last) begin
					cmd.init_resch = (sts.mode == MODE_RESCH);
					state_d = (sts.mode == MODE_RESCH) ? ST_UP_RD : ST_DONE;
				end else begin
					state_d = sts.after_rem ? ST_UP_RD : ST_DN_RD;
				end
			end
			ST_UP_RD: begin
				if (sts.after_rem) cmd.cap_l = 1'b1;
				cmd.rd_parent = 1'b1;
				state_d = sts.hole_root ? ST_DN_RD : ST_UP_CHK;
				if (sts.hole_root && !sts.after_rem) begin
					cmd.put_hole = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_UP_CHK: begin
				if (sts.up_swap) begin
					cmd.up_step = 1'b1;
					state_d = ST_UP_RD;
				end else if (sts.after_rem) begin
					state_d = ST_DN_RD;
				end else begin
					cmd.put_hole = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DN_RD: begin
				if (sts.mode == MODE_RESCH && !sts.after_rem) cmd.cap_l = 1'b1;
				cmd.rd_left = 1'b1;
				state_d = ST_DN_RD2;
			end
			ST_DN_RD2: begin
				cmd.rd_right = 1'b1;
				state_d = ST_DN_CHK;
			end
			ST_DN_CHK: begin
				if (sts.dn_swap) begin
					cmd.dn_step = 1'b1;
					state_d = ST_DN_RD;
				end else begin
					cmd.put_hole = 1'b1;
					if (sts.mode == MODE_RESCH) begin
						cmd.init_resch = 1'b1;
						state_d = ST_UP_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/dtmh_dp.sv =====
module dtmh_dp import dtmh_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req_in,
	input  cmd_t        cmd,
	input  logic [31:0] interval_cap,
	input  logic [2:0]  condemned_code,
	output sts_t        sts,
	output logic        done,
	output rsp_t        rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	req_t        req_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] hole_q;
	logic [CW-1:0] scan_q;
	entry_t      hold_q;      // entry being placed
	entry_t      lch_q;       // left child during sift down
	logic        after_rem_q; // a removal sift is pending
	logic        last_pend_q; // the old last entry is on the read port
	logic        ok_q, peek_q;
	entry_t      peek_ent_q;  // top entry as read, also the task being rescheduled
	logic        done_q;
	rsp_t        rsp_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	dtmh_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Child and parent addresses of the hole, widened to check range.
	logic [AW:0]   left_w, right_w;
	logic [AW-1:0] parent_a;
	assign left_w   = {hole_q, 1'b1};
	assign right_w  = left_w + (AW+1)'(1);
	assign parent_a = AW'((hole_q - AW'(1)) >> 1);

	// Read address selection.
	always_comb begin
		raddr = '0;
		if (cmd.rd_scan) raddr = scan_q[AW-1:0];
		if (cmd.rd_last) raddr = cnt_q[AW-1:0];
		if (cmd.rd_parent) raddr = parent_a;
		if (cmd.rd_left) raddr = left_w[AW-1:0];
		if (cmd.rd_right) raddr = right_w[AW-1:0];
	end

	// Rescheduled task fields, built from the popped top entry.
	logic [32:0] dbl_w, due_w;
	logic [31:0] iv_w;
	entry_t      resch_w;
	always_comb begin
		dbl_w = {peek_ent_q.interval, 1'b0};
		iv_w  = (dbl_w > {1'b0, interval_cap}) ? interval_cap : dbl_w[31:0];
		due_w = {1'b0, req_q.now_time} + {1'b0, iv_w};
		resch_w = peek_ent_q;
		resch_w.interval  = iv_w;
		resch_w.next_time = due_w[32] ? 32'hFFFF_FFFF : due_w[31:0];
		resch_w.retries   = (peek_ent_q.retries == 8'hFF) ? 8'hFF
		                    : peek_ent_q.retries + 8'd1;
	end

	// Sift down choice: smallest strictly less, left before right.
	logic has_l, has_r, pick_r;
	logic [31:0] best_t;
	assign has_l  = (left_w  < (AW+1)'(cnt_q));
	assign has_r  = (right_w < (AW+1)'(cnt_q));
	assign best_t = (has_l && lch_q.next_time < hold_q.next_time) ? lch_q.next_time
	                : hold_q.next_time;
	assign pick_r = has_r && (rdata.next_time < best_t);

	// Memory write selection.
	always_comb begin
		we    = 1'b0;
		waddr = hole_q;
		wdata = hold_q;
		if (cmd.write_mark) begin
			we = 1'b1;
			waddr = scan_q[AW-1:0];
			wdata = rdata;
			wdata.status = condemned_code;
		end
		if (cmd.up_step) begin
			we = 1'b1;
			wdata = rdata;
		end
		if (cmd.dn_step) begin
			we = 1'b1;
			wdata = pick_r ? rdata : lch_q;
		end
		if (cmd.put_hole) begin
			we = 1'b1;
			wdata = hold_q;
		end
	end

	assign sts.mode         = req_q.mode;
	assign sts.full         = (cnt_q == CW'(DEPTH));
	assign sts.empty        = (cnt_q == '0);
	assign sts.due          = (rdata.next_time <= req_q.now_time);
	assign sts.scan_hit     = (rdata.dev == req_q.task_dev);
	assign sts.scan_end     = (scan_q + CW'(1) >= cnt_q);
	assign sts.hole_is_last = (CW'(hole_q) == cnt_q);
	assign sts.hole_root    = (hole_q == '0);
	assign sts.up_swap      = (rdata.next_time > hold_q.next_time);
	assign sts.has_left     = has_l;
	assign sts.has_right    = has_r;
	assign sts.dn_swap      = pick_r || (has_l && lch_q.next_time < hold_q.next_time);
	assign sts.after_rem    = after_rem_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			peek_q      <= 1'b0;
			after_rem_q <= 1'b0;
			last_pend_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			last_pend_q <= cmd.rd_last;
			if (cmd.load_req) begin
				ok_q        <= 1'b0;
				peek_q      <= 1'b0;
				after_rem_q <= 1'b0;
			end
			if (cmd.set_ok) ok_q <= 1'b1;
			if (cmd.set_peek) peek_q <= 1'b1;
			if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cmd.set_hole_scan && req_q.mode == MODE_REM) after_rem_q <= 1'b1;
			// Once the upward pass of a removal ends, the down pass runs.
			if (cmd.rd_left && after_rem_q) after_rem_q <= 1'b0;
			if (cmd.put_hole && after_rem_q) after_rem_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req_in;
			scan_q <= '0;
			hole_q <= '0;
		end
		if (cmd.init_push) begin
			hole_q <= cnt_q[AW-1:0];
			hold_q <= '{dev: req_q.task_dev, next_time: req_q.task_next_time,
			            interval: req_q.task_interval, retries: req_q.task_retries,
			            status: req_q.task_status};
		end
		if (cmd.cap_a) begin
			peek_ent_q <= rdata;
			hold_q     <= rdata;
		end
		if (cmd.scan_next) scan_q <= scan_q + CW'(1);
		if (cmd.set_hole_scan) hole_q <= scan_q[AW-1:0];
		if (cmd.set_hole_top) hole_q <= '0;
		// The moved entry is taken only in the cycle right after its read.
		if (cmd.cap_l && last_pend_q) hold_q <= rdata;
		if (cmd.rd_right) lch_q <= rdata;
		if (cmd.up_step) hole_q <= parent_a;
		if (cmd.dn_step) hole_q <= pick_r ? right_w[AW-1:0] : left_w[AW-1:0];
		if (cmd.init_resch) begin
			hold_q <= resch_w;
			hole_q <= cnt_q[AW-1:0];
		end
		if (cmd.emit) begin
			rsp_q.ok            <= ok_q;
			rsp_q.out_dev       <= peek_q ? peek_ent_q.dev : '0;
			rsp_q.out_next_time <= peek_q ? peek_ent_q.next_time : '0;
			rsp_q.out_interval  <= peek_q ? peek_ent_q.interval : '0;
			rsp_q.out_retries   <= peek_q ? peek_ent_q.retries : '0;
			rsp_q.out_status    <= peek_q ? peek_ent_q.status : '0;
			rsp_q.out_count     <= 7'(cnt_q);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hw/rtl/due_time_min_heap_scheduler_top.sv =====
// Timer queue kept as a binary min-heap of tasks ordered by due time.
// Request channel: drive start with req for one cycle while busy is low;
// the request is taken at that edge and busy stays high until the result.
// Result channel: done pulses for one cycle with rsp valid; the receiver
// cannot stall it and must take it in that cycle.
// Configuration: APB-style writes to interval_cap (address 0) and
// condemned_code (address 4); these must be made only while the block is
// idle, which the block itself does not enforce. Operation: peek reads only
// the top entry; push sifts up level by level; remove and mark scan the
// stored entries one by one, then remove sifts up and down level by level;
// reschedule sifts down then up. The pace of every request is set by the
// single read port of the entry RAM.
// One request is in flight at a time.
// Reset clears the entry count and restores the register defaults; the
// entry RAM is not cleared, since only entries below the count are read.
module due_time_min_heap_scheduler_top import dtmh_pkg::*; #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] cap_q;
	logic [2:0]  cond_q;
	cmd_t        cmd;
	sts_t        sts;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			cond_q <= COND_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_CAP) cap_q <= pwdata;
			else cond_q <= pwdata[2:0];
		end
	end
	assign prdata = (paddr[2] == REG_COND) ? {29'd0, cond_q} : cap_q;

	dtmh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	dtmh_dp #(.DEPTH(HEAP_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_in        (req),
		.cmd           (cmd),
		.interval_cap  (cap_q),
		.condemned_code(cond_q),
		.sts           (sts),
		.done          (done),
		.rsp           (rsp)
	);

endmodule
